// ===== design/leg_alternating_bit_sender_assert.svh =====
// Assertion macros for the alternating-bit sender.
// Used by the controller and the datapath; no other dependencies.
`ifndef LEG_ALTERNATING_BIT_SENDER_ASSERT_SVH
`define LEG_ALTERNATING_BIT_SENDER_ASSERT_SVH
// implication checked every clock outside reset
`define LABS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define LABS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== design/labs_pkg.sv =====
// Alternating-bit sender package: command/event codes, states, ctl/sts structs.
// No dependencies.
`default_nettype none
package labs_pkg;
    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_RX         = 3'd1,
        CMD_TICK       = 3'd2,
        CMD_CONNECT    = 3'd3,
        CMD_DISCONNECT = 3'd4,
        CMD_QRESET     = 3'd5,
        CMD_RECOVER    = 3'd6,
        CMD_NONE       = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_RECORD = 2'd1,
        EV_BYTE   = 2'd2
    } event_t;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SINGLE  = 2'd1;
    localparam logic [1:0] REG_ACK_EV  = 2'd2;
    localparam logic [1:0] REG_ACK_OD  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic   push;      // write request into queue
        logic   pop;       // pop a record into in-flight (mem data valid)
        logic   emit;      // emit in-flight record
        logic   resend;    // count a resend
        logic   wrong;     // count a wrong ack
        logic   clr_q;     // empty queue
        logic   set_wait;
        logic   clr_wait;
        logic   link_set;
        logic   link_clr;
        logic   fwd;       // forward rx byte
        logic   accepted;
        logic   result;    // strobe result this cycle
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic waiting;
        logic link_up;
        logic seq_bit;
        logic timed_out;
    } sts_t;
endpackage
`default_nettype wire

// ===== design/labs_ctrl.sv =====
// Controller of the alternating-bit sender: decodes one request into datapath commands.
// Depends on labs_pkg and leg_alternating_bit_sender_assert.svh.
`default_nettype none
`include "leg_alternating_bit_sender_assert.svh"
module labs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [2:0]    cmd,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          single_in_flight,
    input  wire logic [7:0]    ack_even_byte,
    input  wire logic [7:0]    ack_odd_byte,
    input  labs_pkg::sts_t     sts,
    output logic               busy,
    output labs_pkg::ctl_t     ctl
);
    import labs_pkg::*;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [7:0] rx_reg, rx_next;

    logic is_ack, expected_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_NONE;
            rx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            rx_reg    <= rx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign is_ack = (rx_reg == ack_even_byte) || (rx_reg == ack_odd_byte);
    assign expected_hit = (rx_reg == (sts.seq_bit ? ack_even_byte : ack_odd_byte));

    // ST_READ: decide while the queue read settles; a taken push is applied and strobed here. ST_FINAL: apply, strobe.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rx_next    = rx_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(cmd);
                    rx_next    = rx_byte;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_FINAL;
                if (cmd_reg == CMD_PUSH)
                begin
                    if (single_in_flight)
                    begin
                        if (sts.link_up && !sts.waiting && sts.empty)
                        begin
                            ctl.accepted = 1'b1;
                            ctl.result   = 1'b1;
                            ctl.pop      = 1'b1;   // bypass: send input directly
                            ctl.set_wait = 1'b1;
                            ctl.emit     = sts.link_up;
                            state_next   = ST_IDLE;
                        end
                    end
                    else if (!sts.full)
                    begin
                        ctl.push     = 1'b1;
                        ctl.accepted = 1'b1;
                        ctl.result   = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
                ctl.result = 1'b1;
                case (cmd_reg)
                    CMD_PUSH: ;
                    CMD_RX:
                    begin
                        if (rx_reg != 8'd0)
                        begin
                            if (is_ack)
                            begin
                                if (sts.waiting)
                                begin
                                    ctl.wrong    = !expected_hit;
                                    ctl.clr_wait = sts.empty;
                                    ctl.pop      = !sts.empty;
                                    ctl.set_wait = !sts.empty;
                                    ctl.emit     = !sts.empty && sts.link_up;
                                end
                            end
                            else
                            begin
                                ctl.fwd = 1'b1;
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        if (sts.link_up)
                        begin
                            if (sts.waiting && sts.timed_out)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.resend = 1'b1;
                            end
                            else if (!sts.waiting && !sts.empty)
                            begin
                                ctl.pop      = 1'b1;
                                ctl.set_wait = 1'b1;
                                ctl.emit     = 1'b1;
                            end
                        end
                    end
                    CMD_CONNECT:
                        ctl.link_set = 1'b1;
                    CMD_DISCONNECT:
                    begin
                        ctl.link_clr = 1'b1;
                        ctl.clr_wait = 1'b1;
                        ctl.clr_q    = 1'b1;
                    end
                    CMD_QRESET:
                    begin
                        ctl.clr_wait = 1'b1;
                        ctl.clr_q    = 1'b1;
                    end
                    CMD_RECOVER:
                    begin
                        if (sts.waiting)
                        begin
                            ctl.clr_q = 1'b1;
                            ctl.emit  = sts.link_up;
                        end
                    end
                    default: ;
                endcase
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `LABS_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg))
    `LABS_ASSERT_IMP(a_res_busy, clk, rst_n, ctl.result, busy)
    `LABS_ASSERT_NXT(a_res_idle, clk, rst_n, ctl.result, !busy)
    `LABS_ASSERT_IMP(a_pushpop, clk, rst_n, ctl.push, !ctl.pop)
endmodule
`default_nettype wire

// ===== design/labs_dpath.sv =====
// Datapath of the alternating-bit sender: record queue, in-flight record, counters.
// Depends on labs_pkg and leg_alternating_bit_sender_assert.svh.
`default_nettype none
`include "leg_alternating_bit_sender_assert.svh"
module labs_dpath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  labs_pkg::ctl_t     ctl,
    input  wire logic [31:0]   now_ms,
    input  wire logic [15:0]   resend_timeout_ms,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [31:0]   azimuth_bits,
    input  wire logic [31:0]   inclination_bits,
    input  wire logic [31:0]   roll_bits,
    input  wire logic [31:0]   distance_bits,
    output labs_pkg::sts_t     sts,
    output logic               done,
    output logic [1:0]         event_kind,
    output logic [7:0]         head_byte,
    output logic [31:0]        out_azimuth,
    output logic [31:0]        out_inclination,
    output logic [31:0]        out_roll,
    output logic [31:0]        out_distance,
    output logic               push_accepted,
    output logic               awaiting_ack,
    output logic [5:0]         pending_depth,
    output logic [31:0]        sent_count,
    output logic [31:0]        wrong_ack_count,
    output logic [31:0]        resend_count
);
    import labs_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [127:0] mem [QUEUE_DEPTH];
    logic [127:0] rd_data_reg;
    logic [127:0] in_rec_reg;
    logic [31:0]  now_reg;

    logic [AW-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [CW-1:0] fill_reg;
    logic seq_reg, wait_reg, link_reg, last_seq_reg;
    logic [127:0] last_rec_reg;
    logic [31:0]  last_time_reg, sent_reg, wrong_reg, resend_reg;

    logic [1:0]   ev_kind_reg;
    logic [7:0]   ev_head_reg;
    logic [127:0] ev_rec_reg;
    logic         acc_reg, done_reg;

    logic [127:0] pop_rec;
    logic [31:0]  elapsed;
    logic         bypass;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if ({1'b0, p} == (AW+1)'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_rec_reg <= {azimuth_bits, inclination_bits, roll_bits, distance_bits};
            now_reg    <= now_ms;
        end
        if (ctl.push)
            mem[wr_ptr_reg] <= in_rec_reg;
        rd_data_reg <= mem[rd_ptr_reg];
    end

    assign elapsed = now_reg - last_time_reg;
    assign bypass  = ctl.accepted && ctl.pop;
    assign pop_rec = bypass ? in_rec_reg : rd_data_reg;

    assign sts.empty     = (fill_reg == '0);
    assign sts.full      = (fill_reg >= DEPTH_C);
    assign sts.waiting   = wait_reg;
    assign sts.link_up   = link_reg;
    assign sts.seq_bit   = seq_reg;
    assign sts.timed_out = (elapsed >= {16'd0, resend_timeout_ms});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            seq_reg       <= 1'b0;
            wait_reg      <= 1'b0;
            link_reg      <= 1'b0;
            last_seq_reg  <= 1'b0;
            last_rec_reg  <= '0;
            last_time_reg <= '0;
            sent_reg      <= '0;
            wrong_reg     <= '0;
            resend_reg    <= '0;
            ev_kind_reg   <= EV_NONE;
            ev_head_reg   <= '0;
            ev_rec_reg    <= '0;
            acc_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.result;
            if (ctl.result)
            begin
                acc_reg <= ctl.accepted;
                if (ctl.emit)
                begin
                    ev_kind_reg <= EV_RECORD;
                    ev_head_reg <= {7'd0, ctl.pop ? seq_reg : last_seq_reg};
                    ev_rec_reg  <= ctl.pop ? pop_rec : last_rec_reg;
                end
                else if (ctl.fwd)
                begin
                    ev_kind_reg <= EV_BYTE;
                    ev_head_reg <= rx_byte;
                    ev_rec_reg  <= '0;
                end
                else
                begin
                    ev_kind_reg <= EV_NONE;
                    ev_head_reg <= '0;
                    ev_rec_reg  <= '0;
                end
            end
            if (ctl.push)
            begin
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
                fill_reg   <= fill_reg + 1'b1;
            end
            if (ctl.pop)
            begin
                last_rec_reg <= pop_rec;
                last_seq_reg <= seq_reg;
                seq_reg      <= ~seq_reg;
                if (!bypass)
                begin
                    rd_ptr_reg <= inc_ptr(rd_ptr_reg);
                    fill_reg   <= fill_reg - 1'b1;
                end
            end
            if (ctl.emit)
            begin
                last_time_reg <= now_reg;
                sent_reg      <= sent_reg + 32'd1;
            end
            if (ctl.resend)
                resend_reg <= resend_reg + 32'd1;
            if (ctl.wrong)
                wrong_reg <= wrong_reg + 32'd1;
            if (ctl.clr_wait)
                wait_reg <= 1'b0;
            if (ctl.set_wait)
                wait_reg <= 1'b1;
            if (ctl.link_set)
                link_reg <= 1'b1;
            if (ctl.link_clr)
                link_reg <= 1'b0;
            if (ctl.clr_q)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                fill_reg   <= '0;
            end
        end
    end

    assign done            = done_reg;
    assign event_kind      = ev_kind_reg;
    assign head_byte       = ev_head_reg;
    assign out_azimuth     = ev_rec_reg[127:96];
    assign out_inclination = ev_rec_reg[95:64];
    assign out_roll        = ev_rec_reg[63:32];
    assign out_distance    = ev_rec_reg[31:0];
    assign push_accepted   = acc_reg;
    assign awaiting_ack    = wait_reg;
    assign pending_depth   = 6'(fill_reg + CW'(wait_reg));
    assign sent_count      = sent_reg;
    assign wrong_ack_count = wrong_reg;
    assign resend_count    = resend_reg;

    `LABS_ASSERT_IMP(a_no_ovf, clk, rst_n, ctl.push, !sts.full)
    `LABS_ASSERT_IMP(a_no_udf, clk, rst_n, ctl.pop && !bypass, !sts.empty)
    `LABS_ASSERT_IMP(a_fill, clk, rst_n, 1'b1, fill_reg <= DEPTH_C)
    `LABS_ASSERT_NXT(a_emit_cnt, clk, rst_n, ctl.emit, sent_reg == $past(sent_reg) + 32'd1)
endmodule
`default_nettype wire

// ===== design/leg_alternating_bit_sender.sv =====
// Alternating-bit stop-and-wait sender: top level, config registers, two submodules.
// Depends on labs_pkg, labs_ctrl, labs_dpath.
//
// Usage:
//   Request channel: drive cmd, now_ms, rx_byte and the four record words and
//   raise start; the request is taken at a clock edge where start is high and
//   busy is low. busy drops in the cycle in which the result is shown.
//   Result channel: done pulses for one cycle with all result ports valid;
//   the receiver cannot stall, it must take the result in that cycle.
//   Result path: a push that is taken (queued, or sent at once in single in
//   flight mode) gives its result from the decode state ST_READ; every other
//   request gives it from ST_FINAL, after ST_READ has left time for the queue
//   memory read.
//   One request at a time: a new request is taken only when busy is low again,
//   after the controller's decode / queue read / update sequence.
//   Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
//   the user must write only while the block is idle, the block does not enforce it.
//   Reset: queue empty, link down, no ACK awaited, counters zero, registers
//   at defaults (timeout 5000 ms, single in flight, ACK bytes 0x55 / 0x56).
`default_nettype none
module leg_alternating_bit_sender #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] now_ms,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [31:0] azimuth_bits,
    input  wire logic [31:0] inclination_bits,
    input  wire logic [31:0] roll_bits,
    input  wire logic [31:0] distance_bits,
    output logic             done,
    output logic [1:0]       event_kind,
    output logic [7:0]       head_byte,
    output logic [31:0]      out_azimuth,
    output logic [31:0]      out_inclination,
    output logic [31:0]      out_roll,
    output logic [31:0]      out_distance,
    output logic             push_accepted,
    output logic             awaiting_ack,
    output logic [5:0]       pending_depth,
    output logic [31:0]      sent_count,
    output logic [31:0]      wrong_ack_count,
    output logic [31:0]      resend_count
);
    import labs_pkg::*;

    logic [15:0] timeout_reg;
    logic        single_reg;
    logic [7:0]  ack_ev_reg, ack_od_reg;
    logic [7:0]  rx_hold_reg;
    ctl_t        ctl;
    sts_t        sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd5000;
            single_reg  <= 1'b1;
            ack_ev_reg  <= 8'h55;
            ack_od_reg  <= 8'h56;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_SINGLE:  single_reg  <= cfg_data[0];
                REG_ACK_EV:  ack_ev_reg  <= cfg_data[7:0];
                REG_ACK_OD:  ack_od_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            rx_hold_reg <= rx_byte;
    end

    labs_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .cmd              (cmd),
        .rx_byte          (rx_byte),
        .single_in_flight (single_reg),
        .ack_even_byte    (ack_ev_reg),
        .ack_odd_byte     (ack_od_reg),
        .sts              (sts),
        .busy             (busy),
        .ctl              (ctl)
    );

    labs_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .ctl               (ctl),
        .now_ms            (now_ms),
        .resend_timeout_ms (timeout_reg),
        .rx_byte           (rx_hold_reg),
        .azimuth_bits      (azimuth_bits),
        .inclination_bits  (inclination_bits),
        .roll_bits         (roll_bits),
        .distance_bits     (distance_bits),
        .sts               (sts),
        .done              (done),
        .event_kind        (event_kind),
        .head_byte         (head_byte),
        .out_azimuth       (out_azimuth),
        .out_inclination   (out_inclination),
        .out_roll          (out_roll),
        .out_distance      (out_distance),
        .push_accepted     (push_accepted),
        .awaiting_ack      (awaiting_ack),
        .pending_depth     (pending_depth),
        .sent_count        (sent_count),
        .wrong_ack_count   (wrong_ack_count),
        .resend_count      (resend_count)
    );
endmodule
`default_nettype wire
